// ===== sv/bamp_pkg.sv =====
// Package for the byte-addressed memory port.
// Holds the size constants, field codes and the payload and control struct types.
// No dependencies.
package bamp_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int SIZE_W    = ADDR_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [1:0] ACC_BYTE = 2'd0;
   localparam logic [1:0] ACC_HALF = 2'd1;
   localparam logic [1:0] ACC_WORD = 2'd2;
   localparam logic [1:0] ACC_RSVD = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BIG_ENDIAN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE       = 1'b1;

   typedef struct packed {
      logic        func;
      logic [1:0]  access_size;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic issue;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_err;
      logic last_lane;
   } dp_stat_type;

endpackage

// ===== sv/byte_addressed_memory_port.sv =====
// Top level of the byte-addressed memory port with selectable byte order.
// Joins bamp_ctrl and bamp_dp; depends on bamp_pkg.
//
//   channel   ports                                  handshake
//   request   start, busy, req_data                  taken when start && !busy
//   response  rsp_valid, rsp_data                    one-cycle strobe, no stall
//   config    csr_we, csr_index, csr_wdata           taken when csr_we
//
// An in-range access of n bytes (1, 2 or 4) passes the check state, the access state
// once per byte, the drain state and the response state, and the next item can be
// taken in that response cycle. A refused access goes from check straight to response.
// The single-port byte memory, one byte per cycle, sets the per-byte cost.
// Reset is synchronous and active high; memory contents are not cleared.
// The receiver cannot hold responses off.
module byte_addressed_memory_port
   import bamp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   bamp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   bamp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/bamp_ctrl.sv =====
// Controller state machine of the byte-addressed memory port.
// Sequences check, byte accesses and response; depends on bamp_pkg.
module bamp_ctrl
   import bamp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_ACCESS = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy      = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd       = '0;
      cmd.load  = accept;
      cmd.check = (state_ff == ST_CHECK);
      cmd.issue = (state_ff == ST_ACCESS);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.range_err ? ST_RESP : ST_ACCESS;
         end
         ST_ACCESS: begin
            if (stat.last_lane) state_in = ST_DRAIN;
         end
         // The last read byte sits in the memory output register now and is written into the result register.
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = accept ? ST_CHECK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted item did not enter the check state");

   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

endmodule

// ===== sv/bamp_dp.sv =====
// Datapath of the byte-addressed memory port: request and config registers,
// bound check, byte memory and read assembly; depends on bamp_pkg.
module bamp_dp
   import bamp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat,
   output rsp_type               rsp_data
);

   logic [7:0]        mem [MEM_BYTES];

   req_type           req_ff;
   logic              big_endian_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [1:0]        lane_ff;
   logic [1:0]        lane_d_ff;
   logic              rd_pend_ff;
   logic [7:0]        mem_q_ff;
   logic [31:0]       rdata_ff;
   logic              status_ff;

   logic [2:0]        nbytes;
   logic [1:0]        last_idx;
   logic [1:0]        offset;
   logic [32:0]       end_addr;
   logic [SIZE_W-1:0] eff_size;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        wbyte;

   // Reserved size shifts out to zero bytes; it is refused anyway.
   assign nbytes   = 3'b001 << req_ff.access_size;
   assign last_idx = 2'(nbytes - 3'd1);
   assign offset   = big_endian_ff ? (last_idx - lane_ff) : lane_ff;
   assign end_addr = {1'b0, req_ff.address} + 33'(nbytes);
   assign eff_size = (size_ff > SIZE_W'(MEM_BYTES)) ? SIZE_W'(MEM_BYTES) : size_ff;
   assign mem_addr = req_ff.address[ADDR_W-1:0] + ADDR_W'(offset);
   assign wbyte    = req_ff.write_data[8*lane_ff +: 8];

   always_comb begin
      stat           = '0;
      stat.range_err = (req_ff.access_size == ACC_RSVD) || (end_addr > 33'(eff_size));
      stat.last_lane = (lane_ff == last_idx);
   end

   assign rsp_data = '{read_data: rdata_ff, status: status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         size_ff       <= SIZE_W'(MEM_BYTES);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
            CSR_SIZE:       size_ff       <= csr_wdata[SIZE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      lane_d_ff <= lane_ff;
      if (cmd.load) begin
         lane_ff <= '0;
      end else if (cmd.issue) begin
         lane_ff <= lane_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         rdata_ff   <= '0;
         status_ff  <= STATUS_OK;
      end else begin
         rd_pend_ff <= cmd.issue && (req_ff.func == FUNC_READ);
         if (cmd.load) begin
            rdata_ff <= '0;
         end else if (rd_pend_ff) begin
            rdata_ff[8*lane_d_ff +: 8] <= mem_q_ff;
         end
         if (cmd.load) begin
            status_ff <= STATUS_OK;
         end else if (cmd.check) begin
            status_ff <= stat.range_err ? STATUS_RANGE : STATUS_OK;
         end
      end
   end

   // Single-port byte memory, one byte per cycle.
   always_ff @(posedge clock) begin
      if (cmd.issue && (req_ff.func == FUNC_WRITE)) begin
         mem[mem_addr] <= wbyte;
      end
      mem_q_ff <= mem[mem_addr];
   end

   a_no_access_on_error: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status_ff == STATUS_OK)
      else $error("memory accessed for a refused item");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      status_ff == STATUS_RANGE |-> rdata_ff == '0)
      else $error("refused item carries nonzero read data");

endmodule
